FILE: hdl/spwin_pkg.sv
`timescale 1ns / 1ps

package spwin_pkg;

   // Build-time defaults and fixed widths
   localparam int MAX_FRAME_DEF = 4096;
   localparam int SAMPLE_BITS   = 16;
   localparam int COEFF_BITS    = 17;   // unsigned Q15, 32768 is 1.0
   localparam int PH_W          = 17;   // phase in turns of 2^16, one extra bit for a full turn
   localparam int QUEUE_DEPTH   = 2;    // power of two
   localparam int DEN_W         = 64;
   localparam int MANT_W        = 24;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_WINDOW_KIND   = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [1:0] CSR_SCALING_MODE  = 2'd2;
   localparam logic [1:0] CSR_SAMPLE_RATE   = 2'd3;

   // Window kinds
   localparam logic [2:0] WIN_RECT     = 3'd0;
   localparam logic [2:0] WIN_HANN     = 3'd1;
   localparam logic [2:0] WIN_HAMMING  = 3'd2;
   localparam logic [2:0] WIN_BLACKMAN = 3'd3;

   // Scaling modes
   localparam logic [1:0] MODE_DENSITY  = 2'd0;
   localparam logic [1:0] MODE_SPECTRUM = 2'd1;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_KIND = 2'd1;
   localparam logic [1:0] STATUS_BAD_MODE = 2'd2;

   localparam logic [COEFF_BITS-1:0] ONE_Q15 = 17'd32768;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_re;
      logic signed [SAMPLE_BITS-1:0] sample_im;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] win_re;
      logic signed [SAMPLE_BITS-1:0] win_im;
      logic                          frame_end;
      logic [MANT_W-1:0]             scale_mantissa;
      logic signed [7:0]             scale_exponent;
      logic [1:0]                    status;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]  window_kind;
      logic [12:0] window_length;
      logic [1:0]  scaling_mode;
      logic [26:0] sample_rate;
   } cfg_type;

   // One classified sample handed from front to back
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic [COEFF_BITS-1:0]         w;
      logic                          last;
      logic                          kind_ok;
      logic [1:0]                    status;
   } job_type;

   typedef enum logic [3:0] {
      F_IDLE, F_DIV, F_CZ2, F_CT1, F_CT2, F_CY, F_WMUL, F_WSUM, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_MUL, B_ACC, B_NORMQ, B_MLO, B_MHI, B_SQR, B_NORMD, B_DIV, B_FIN, B_OUT
   } back_state_type;

endpackage

FILE: hdl/spwin_queue.sv
`timescale 1ns / 1ps

module spwin_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  spwin_pkg::job_type push_data,
   input  logic              pop,
   output logic              empty,
   output spwin_pkg::job_type pop_data
);
   import spwin_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rp_ff];

   // pointer and fill count
   always_comb begin
      wp_in  = do_push ? PTR_W'(wp_ff + 1'b1) : wp_ff;
      rp_in  = do_pop  ? PTR_W'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/spwin_front.sv
`timescale 1ns / 1ps

module spwin_front #(
   parameter int MAX_FRAME = spwin_pkg::MAX_FRAME_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spwin_pkg::cfg_type     cfg,
   input  logic                   req_push,
   output logic                   req_full,
   input  spwin_pkg::req_word_type req_data,
   output logic                   job_push,
   input  logic                   job_full,
   output spwin_pkg::job_type     job_data
);
   import spwin_pkg::*;

   localparam int IDX_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int REM_W = IDX_W + 1;
   localparam logic signed [32:0] HAM_BASE = 33'sd579829760;  // 17695 * 32768
   localparam logic signed [32:0] BLK_BASE = 33'sd450985984;  // 13763 * 32768

   // fold a phase to a quarter turn: {negative, z in Q14}
   function automatic logic [15:0] fold(input logic [15:0] p);
      logic [14:0] x;
      logic [14:0] z;
      x = p[14:0];
      z = (x <= 15'd16384) ? x : 15'(16'd32768 - {1'b0, x});
      return {p[15], z};
   endfunction

   front_state_type       state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   req_word_type          smp_ff, smp_in;
   logic                  last_ff, last_in;
   logic [1:0]            status_ff, status_in;
   logic [2:0]            kind_ff, kind_in;
   logic [IDX_W-1:0]      dvs_ff, dvs_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [PH_W-1:0]       ph_ff, ph_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  pass_ff, pass_in;
   logic [14:0]           z_ff, z_in, z2_ff, z2_in;
   logic                  neg_ff, neg_in;
   logic [16:0]           t_ff, t_in;
   logic signed [17:0]    c1_ff, c1_in, c2_ff, c2_in;
   logic signed [32:0]    pa_ff, pa_in, pb_ff, pb_in;
   logic [COEFF_BITS-1:0] w_ff, w_in;

   logic [31:0]           len_c;
   logic [IDX_W-1:0]      d_cur, n_cur;
   logic                  last_cur;
   logic                  geq;
   logic [REM_W-1:0]      rem_sub;
   logic [PH_W-1:0]       ph_new;
   logic [15:0]           fold1, fold2;
   logic [29:0]           zz;
   logic [27:0]           m1;
   logic [31:0]           m2, m3;
   logic [16:0]           y;
   logic signed [17:0]    c_new;
   logic signed [17:0]    hann_v;
   logic signed [32:0]    num;
   logic signed [32:0]    num_q;

   // frame length clamp and position in the frame
   always_comb begin
      if (cfg.window_length < 13'd2) begin
         len_c = 32'd2;
      end else if (32'(cfg.window_length) > 32'(MAX_FRAME)) begin
         len_c = 32'(MAX_FRAME);
      end else begin
         len_c = 32'(cfg.window_length);
      end
   end

   assign d_cur    = IDX_W'(len_c - 32'd1);
   assign last_cur = (idx_ff >= d_cur);
   assign n_cur    = last_cur ? d_cur : idx_ff;

   // one restoring step of the phase divider
   assign geq     = (rem_ff >= {1'b0, dvs_ff});
   assign rem_sub = geq ? REM_W'(rem_ff - {1'b0, dvs_ff}) : rem_ff;
   assign ph_new  = {ph_ff[PH_W-2:0], geq};
   assign fold1   = fold(16'(ph_new[15:0] + 16'd16384));
   assign fold2   = fold(16'({ph_ff[14:0], 1'b0} + 16'd16384));

   // shared sine polynomial unit, one multiply per step
   assign zz     = 30'(z_ff) * 30'(z_ff);
   assign m1     = 28'd4640 * 28'(z2_ff);
   assign m2     = 32'(t_ff) * 32'(z2_ff);
   assign m3     = 32'(z_ff) * 32'(t_ff);
   assign y      = m3[31:15];
   assign c_new  = neg_ff ? -$signed({1'b0, y}) : $signed({1'b0, y});

   // coefficient combine
   assign hann_v = 18'sd32768 - c1_ff;
   assign num    = ((kind_ff == WIN_HAMMING) ? HAM_BASE : BLK_BASE) + pa_ff + pb_ff;
   assign num_q  = num >>> 15;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      smp_in    = smp_ff;
      last_in   = last_ff;
      status_in = status_ff;
      kind_in   = kind_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      ph_in     = ph_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      z_in      = z_ff;
      z2_in     = z2_ff;
      neg_in    = neg_ff;
      t_in      = t_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      w_in      = w_ff;
      req_full  = (state_ff != F_IDLE);
      job_push  = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               smp_in  = req_data;
               kind_in = cfg.window_kind;
               last_in = last_cur;
               dvs_in  = d_cur;
               rem_in  = {1'b0, n_cur};
               ph_in   = '0;
               cnt_in  = '0;
               idx_in  = last_cur ? '0 : IDX_W'(idx_ff + 1'b1);
               if (cfg.window_kind > WIN_BLACKMAN) begin
                  status_in = STATUS_BAD_KIND;
               end else if (cfg.scaling_mode > MODE_SPECTRUM) begin
                  status_in = STATUS_BAD_MODE;
               end else begin
                  status_in = STATUS_OK;
               end
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = {rem_sub[IDX_W-1:0], 1'b0};
            ph_in  = ph_new;
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'(PH_W - 1)) begin
               {neg_in, z_in} = fold1;
               pass_in        = 1'b0;
               state_in       = F_CZ2;
            end
         end
         F_CZ2: begin
            z2_in    = zz[28:14];
            state_in = F_CT1;
         end
         F_CT1: begin
            t_in     = 17'd42048 - 17'(m1[27:14]);
            state_in = F_CT2;
         end
         F_CT2: begin
            t_in     = 17'd102944 - 17'(m2[31:14]);
            state_in = F_CY;
         end
         F_CY: begin
            if (!pass_ff) begin
               c1_in          = c_new;
               {neg_in, z_in} = fold2;
               pass_in        = 1'b1;
               state_in       = F_CZ2;
            end else begin
               c2_in    = c_new;
               state_in = F_WMUL;
            end
         end
         F_WMUL: begin
            case (kind_ff)
               WIN_HAMMING: begin
                  pa_in = -(33'sd15073 * 33'(c1_ff));
                  pb_in = '0;
               end
               WIN_BLACKMAN: begin
                  pa_in = -(33'(c1_ff) <<< 14);
                  pb_in = 33'sd2621 * 33'(c2_ff);
               end
               default: begin
                  pa_in = '0;
                  pb_in = '0;
               end
            endcase
            state_in = F_WSUM;
         end
         F_WSUM: begin
            case (kind_ff)
               WIN_RECT: w_in = ONE_Q15;
               WIN_HANN: w_in = COEFF_BITS'(hann_v[17:1]);
               WIN_HAMMING, WIN_BLACKMAN: begin
                  if (num < 0) begin
                     w_in = '0;
                  end else if (num_q > 33'sd32768) begin
                     w_in = ONE_Q15;
                  end else begin
                     w_in = num_q[COEFF_BITS-1:0];
                  end
               end
               default: w_in = '0;
            endcase
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign job_data.re      = smp_ff.sample_re;
   assign job_data.im      = smp_ff.sample_im;
   assign job_data.w       = w_ff;
   assign job_data.last    = last_ff;
   assign job_data.kind_ok = (status_ff != STATUS_BAD_KIND);
   assign job_data.status  = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff    <= smp_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      kind_ff   <= kind_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      ph_ff     <= ph_in;
      cnt_ff    <= cnt_in;
      pass_ff   <= pass_in;
      z_ff      <= z_in;
      z2_ff     <= z2_in;
      neg_ff    <= neg_in;
      t_ff      <= t_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      w_ff      <= w_in;
   end

endmodule

FILE: hdl/spwin_back.sv
`timescale 1ns / 1ps

module spwin_back #(
   parameter int MAX_FRAME = spwin_pkg::MAX_FRAME_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spwin_pkg::cfg_type      cfg,
   output logic                    job_pop,
   input  logic                    job_empty,
   input  spwin_pkg::job_type      job_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output spwin_pkg::rsp_word_type rsp_data
);
   import spwin_pkg::*;

   localparam int IDX_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int SUM_W = IDX_W + 17;
   localparam int SQ_W  = IDX_W + 31;

   // Q1.15 product back to a sample: round half up, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [33:0] p);
      logic signed [33:0] s;
      s = (p + 34'sd16384) >>> 15;
      if (s > 34'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -34'sd32768) begin
         return 16'sh8000;
      end else begin
         return s[SAMPLE_BITS-1:0];
      end
   endfunction

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic signed [33:0] pre_ff, pre_in, pim_ff, pim_in;
   logic [30:0]        wsq_ff, wsq_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [SQ_W-1:0]    qv_ff, qv_in;
   logic [7:0]         shr_ff, shr_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [6:0]         nsh_ff, nsh_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic [MANT_W:0]    quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   rsp_word_type       res_ff, res_in;
   rsp_word_type       out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic [33:0]        wsq_full;
   logic [SUM_W-1:0]   sum_new;
   logic [SQ_W-1:0]    sq_new;
   logic [35:0]        q36;
   logic [44:0]        fs_lo, fs_hi;
   logic [2*SUM_W-1:0] sum_sq;
   logic               dgeq;
   logic [DEN_W:0]     dsub;
   logic signed [10:0] ex;

   assign wsq_full = 34'(job_ff.w) * 34'(job_ff.w);
   assign sum_new  = sum_ff + SUM_W'(job_ff.w);
   assign sq_new   = sq_ff + SQ_W'(wsq_ff);
   assign q36      = 36'(qv_ff);
   assign fs_lo    = 45'(cfg.sample_rate) * 45'(q36[17:0]);
   assign fs_hi    = 45'(cfg.sample_rate) * 45'(q36[35:18]);
   assign sum_sq   = (2*SUM_W)'(qv_ff[SUM_W-1:0]) * (2*SUM_W)'(qv_ff[SUM_W-1:0]);

   // one restoring step of the reciprocal divider
   assign dgeq = (rem_ff >= {1'b0, den_ff});
   assign dsub = dgeq ? (DEN_W+1)'(rem_ff - {1'b0, den_ff}) : rem_ff;

   // exponent = e - bit_length(den) (+1 when the quotient hit 2.0)
   assign ex = 11'(nsh_ff) - 11'(shr_ff) + 11'(quo_ff[MANT_W]) - 11'sd34;

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pre_in       = pre_ff;
      pim_in       = pim_ff;
      wsq_in       = wsq_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      qv_in        = qv_ff;
      shr_in       = shr_ff;
      den_in       = den_ff;
      nsh_in       = nsh_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      job_pop      = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            pre_in   = 34'(job_ff.re) * $signed({17'd0, job_ff.w});
            pim_in   = 34'(job_ff.im) * $signed({17'd0, job_ff.w});
            wsq_in   = wsq_full[30:0];
            state_in = B_ACC;
         end
         B_ACC: begin
            res_in.frame_end      = job_ff.last;
            res_in.status         = job_ff.status;
            res_in.scale_mantissa = '0;
            res_in.scale_exponent = '0;
            if (job_ff.kind_ok) begin
               res_in.win_re = round_sat(pre_ff);
               res_in.win_im = round_sat(pim_ff);
               sum_in        = sum_new;
               sq_in         = sq_new;
            end else begin
               res_in.win_re = '0;
               res_in.win_im = '0;
            end
            shr_in   = '0;
            state_in = B_OUT;
            if (job_ff.last) begin
               sum_in = '0;
               sq_in  = '0;
               if (cfg.scaling_mode == MODE_DENSITY) begin
                  qv_in    = job_ff.kind_ok ? sq_new : sq_ff;
                  state_in = B_NORMQ;
               end else if (cfg.scaling_mode == MODE_SPECTRUM) begin
                  qv_in    = SQ_W'(job_ff.kind_ok ? sum_new : sum_ff);
                  state_in = B_SQR;
               end
            end
         end
         // bring the square sum under 36 bits
         B_NORMQ: begin
            if ((qv_ff >> 36) != '0) begin
               qv_in  = qv_ff >> 1;
               shr_in = 8'(shr_ff + 1'b1);
            end else begin
               state_in = B_MLO;
            end
         end
         B_MLO: begin
            den_in   = DEN_W'(fs_lo);
            state_in = B_MHI;
         end
         B_MHI: begin
            den_in   = den_ff + (DEN_W'(fs_hi) << 18);
            nsh_in   = '0;
            state_in = B_NORMD;
         end
         B_SQR: begin
            den_in   = DEN_W'(sum_sq);
            nsh_in   = '0;
            state_in = B_NORMD;
         end
         // left-justify the denominator, counting the shift
         B_NORMD: begin
            if (den_ff == '0) begin
               res_in.scale_mantissa = '1;
               res_in.scale_exponent = '0;
               state_in              = B_OUT;
            end else if (den_ff[DEN_W-1]) begin
               rem_in   = {2'b01, {(DEN_W-1){1'b0}}};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = B_DIV;
            end else begin
               den_in = den_ff << 1;
               nsh_in = 7'(nsh_ff + 1'b1);
            end
         end
         B_DIV: begin
            quo_in = {quo_ff[MANT_W-1:0], dgeq};
            rem_in = {dsub[DEN_W-1:0], 1'b0};
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'(MANT_W)) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (ex > 11'sd0) begin
               res_in.scale_mantissa = '1;
               res_in.scale_exponent = '0;
            end else if (ex < -11'sd96) begin
               res_in.scale_mantissa = '0;
               res_in.scale_exponent = -8'sd96;
            end else begin
               res_in.scale_mantissa = quo_ff[MANT_W] ? quo_ff[MANT_W:1] : quo_ff[MANT_W-1:0];
               res_in.scale_exponent = ex[7:0];
            end
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= '0;
         sq_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pre_ff <= pre_in;
      pim_ff <= pim_in;
      wsq_ff <= wsq_in;
      qv_ff  <= qv_in;
      shr_ff <= shr_in;
      den_ff <= den_in;
      nsh_ff <= nsh_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

endmodule

FILE: hdl/spectral_window_with_scale.sv
`timescale 1ns / 1ps

// Spectral window with frame scale factor. Each word is one complex Q1.15
// sample; both parts are multiplied by the selected window coefficient
// (rectangular, Hann, Hamming, Blackman) and one result word comes out per
// sample. On the last sample of a frame the word also carries the density or
// spectrum scale factor as a Q1.23 mantissa and a power-of-two exponent. The
// front runs a 17-step bit-serial phase divider and two passes through a
// shared four-step cosine multiplier set for each sample. The back multiplies
// and accumulates each ordinary sample, and on a frame end adds the
// denominator normalize and the 25-step reciprocal divider. A two-word
// queue between front and back and an output register let the next sample
// be taken while results wait. Registers must be written through the csr
// port only while the block is idle; the block itself does not enforce this.

module spectral_window_with_scale #(
   parameter int MAX_FRAME = spwin_pkg::MAX_FRAME_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  spwin_pkg::req_word_type req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output spwin_pkg::rsp_word_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [26:0]             csr_data
);
   import spwin_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wr, job_rd;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_KIND:   cfg_in.window_kind   = csr_data[2:0];
            CSR_WINDOW_LENGTH: cfg_in.window_length = csr_data[12:0];
            CSR_SCALING_MODE:  cfg_in.scaling_mode  = csr_data[1:0];
            CSR_SAMPLE_RATE:   cfg_in.sample_rate   = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_kind   <= WIN_RECT;
         cfg_ff.window_length <= 13'd1024;
         cfg_ff.scaling_mode  <= MODE_DENSITY;
         cfg_ff.sample_rate   <= 27'd48000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spwin_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_push (job_push),
      .job_full (job_full),
      .job_data (job_wr)
   );

   spwin_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_wr),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_rd)
   );

   spwin_back #(.MAX_FRAME(MAX_FRAME)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_pop   (job_pop),
      .job_empty (job_empty),
      .job_data  (job_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // scale fields only on a frame end
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.frame_end) |->
         (rsp_data.scale_mantissa == '0 && rsp_data.scale_exponent == '0))
      else $error("scale fields set off a frame end");

   // invalid window kind gives zero samples
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STATUS_BAD_KIND) |->
         (rsp_data.win_re == '0 && rsp_data.win_im == '0))
      else $error("nonzero sample with invalid window kind");

   // mantissa is normalized or zero
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty) |->
         (rsp_data.scale_mantissa == '0 || rsp_data.scale_mantissa[MANT_W-1]))
      else $error("scale mantissa not normalized");

endmodule

FILE: tb/tb_spectral_window_with_scale.sv
`timescale 1ns / 1ps

module tb_spectral_window_with_scale;
   import spwin_pkg::*;

   localparam int MAX_CYCLES = 3000000;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_word_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   rsp_word_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [26:0] csr_data;

   spectral_window_with_scale u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor copy of registers and frame state
   logic [2:0] p_kind;
   logic [12:0] p_len;
   logic [1:0] p_mode;
   logic [26:0] p_rate;
   logic [11:0] p_index;
   logic [63:0] p_sum;
   logic [63:0] p_sqsum;

   rsp_word_type expected_words[$];
   int error_count;
   int cycle_count;
   bit quiet;      // no idling in the last part
   bit in_reset;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("tb_spectral_window_with_scale: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // quarter-wave polynomial sine, phase in turns of 2^16
   function automatic longint turn_sine(input longint p);
      longint x, z, z2, t, y;
      x = p & 32'h7FFF;
      z = (x <= 16384) ? x : (32768 - x);
      z2 = (z * z) >>> 14;
      t = (4640 * z2) >>> 14;
      t = 42048 - t;
      t = (t * z2) >>> 14;
      t = 102944 - t;
      y = (z * t) >>> 15;
      return (p & 32'h8000) ? -y : y;
   endfunction

   function automatic longint turn_cosine(input longint p);
      return turn_sine(((p & 32'hFFFF) + 16384) & 32'hFFFF);
   endfunction

   function automatic longint window_coeff(input logic [2:0] kind, input longint n,
                                           input longint m);
      longint ph, c1, c2, num;
      ph = (n << 16) / (m - 1);
      c1 = turn_cosine(ph);
      c2 = turn_cosine(2 * ph);
      case (kind)
         WIN_HANN: return (32768 - c1) >>> 1;
         WIN_HAMMING: num = 17695 * 32768 - 15073 * c1;
         WIN_BLACKMAN: num = 13763 * 32768 - 16384 * c1 + 2621 * c2;
         default: return 32768;
      endcase
      if (num < 0) num = 0;
      num = num >>> 15;
      if (num > 32768) num = 32768;
      return num;
   endfunction

   function automatic logic [15:0] windowed(input logic signed [15:0] x, input longint w);
      longint q;
      q = (longint'(x) * w + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic int bit_len(input logic [63:0] v);
      int n;
      n = 0;
      while (v != 0) begin
         v = v >> 1;
         n++;
      end
      return n;
   endfunction

   // 2^e / den as Q1.23 mantissa and exponent
   task automatic frame_scale(input logic [63:0] den, input int e,
                              output logic [23:0] mant, output logic signed [7:0] expo);
      int s, ex;
      logic [127:0] r, q;
      if (den == 0) begin
         mant = 24'hFFFFFF;
         expo = '0;
         return;
      end
      s = bit_len(den) + 23;
      r = 0;
      q = 0;
      for (int i = s; i >= 0; i--) begin
         r = (r << 1) | 128'(i == s);
         q = q << 1;
         if (r >= {64'd0, den}) begin
            r = r - {64'd0, den};
            q[0] = 1'b1;
         end
      end
      if (q >= (128'd1 << 24)) begin
         q = q >> 1;
         s--;
      end
      ex = e + 23 - s;
      if (ex > 0) begin
         mant = 24'hFFFFFF;
         expo = '0;
      end else if (ex < -96) begin
         mant = '0;
         expo = -8'sd96;
      end else begin
         mant = q[23:0];
         expo = 8'(ex);
      end
   endtask

   task automatic predict_window(input req_word_type x, output rsp_word_type y);
      longint m, n, w;
      int bl, r;
      logic [63:0] den;
      bit last;
      y = '0;
      m = p_len;
      if (m < 2) m = 2;
      if (m > MAX_FRAME_DEF) m = MAX_FRAME_DEF;
      n = (p_index > m - 1) ? m - 1 : p_index;
      y.status = STATUS_OK;
      if (p_kind <= WIN_BLACKMAN) begin
         w = window_coeff(p_kind, n, m);
         y.win_re = windowed(x.sample_re, w);
         y.win_im = windowed(x.sample_im, w);
         p_sum += w;
         p_sqsum += w * w;
      end else begin
         y.status = STATUS_BAD_KIND;
      end
      if (y.status == STATUS_OK && p_mode > MODE_SPECTRUM) y.status = STATUS_BAD_MODE;
      last = p_index >= m - 1;
      y.frame_end = last;
      if (last) begin
         if (p_mode == MODE_DENSITY) begin
            bl = bit_len(p_sqsum);
            r = (bl > 36) ? bl - 36 : 0;
            den = 64'(p_rate) * (p_sqsum >> r);
            frame_scale(den, 30 - r, y.scale_mantissa, y.scale_exponent);
         end else if (p_mode == MODE_SPECTRUM) begin
            frame_scale(p_sum * p_sum, 30, y.scale_mantissa, y.scale_exponent);
         end
         p_index = '0;
         p_sum = '0;
         p_sqsum = '0;
      end else begin
         p_index++;
      end
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin
      int stall;
      rsp_word_type want;
      rsp_pop = 1'b0;
      stall = 0;
      @(posedge clock);
      while (in_reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.win_re !== want.win_re)
                  report_mismatch("win_re", rsp_data.win_re, want.win_re);
               if (rsp_data.win_im !== want.win_im)
                  report_mismatch("win_im", rsp_data.win_im, want.win_im);
               if (rsp_data.frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_data.frame_end, want.frame_end);
               if (rsp_data.scale_mantissa !== want.scale_mantissa)
                  report_mismatch("scale_mantissa", rsp_data.scale_mantissa,
                                  want.scale_mantissa);
               if (rsp_data.scale_exponent !== want.scale_exponent)
                  report_mismatch("scale_exponent", rsp_data.scale_exponent,
                                  want.scale_exponent);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [26:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WINDOW_KIND: p_kind = value[2:0];
         CSR_WINDOW_LENGTH: p_len = value[12:0];
         CSR_SCALING_MODE: p_mode = value[1:0];
         default: p_rate = value;
      endcase
      @(posedge clock);
   endtask

   // wait for every result, then let the back end settle
   task automatic drain;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // one sample, with optional random gap before it
   task automatic send_sample(input req_word_type x);
      rsp_word_type y;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= x;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_window(x, y);
      expected_words.push_back(y);
   endtask

   function automatic logic [15:0] rand_part;
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   typedef struct {
      logic [15:0] re;
      logic [15:0] im;
      bit          typed;      // expectation typed in below
      logic [15:0] want_re;
      logic [15:0] want_im;
      logic        want_end;
      logic [1:0]  want_status;
   } directed_row_type;

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      req_word_type x;
      rsp_word_type y;
      logic [26:0] rate;
      int kind_sel;
      error_count = 0;
      cycle_count = 0;
      quiet = 0;
      in_reset = 1;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WINDOW_KIND;
      csr_data = '0;
      p_kind = WIN_RECT;
      p_len = 13'd1024;
      p_mode = MODE_DENSITY;
      p_rate = 27'd48000;
      p_index = '0;
      p_sum = '0;
      p_sqsum = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      in_reset = 0;
      @(posedge clock);

      // directed: rectangular, short frames, extremes pass through unchanged
      write_reg(CSR_WINDOW_LENGTH, 27'd2);
      rows = '{
         '{16'h7FFF, 16'h8000, 1, 16'h7FFF, 16'h8000, 1'b0, STATUS_OK},
         '{16'h8000, 16'h7FFF, 1, 16'h8000, 16'h7FFF, 1'b1, STATUS_OK},
         '{16'h0000, 16'hFFFF, 1, 16'h0000, 16'hFFFF, 1'b0, STATUS_OK},
         '{16'h1234, 16'hABCD, 1, 16'h1234, 16'hABCD, 1'b1, STATUS_OK}
      };
      foreach (rows[i]) begin
         x.sample_re = rows[i].re;
         x.sample_im = rows[i].im;
         send_sample(x);
         if (rows[i].typed) begin
            y = expected_words[$];
            if (y.win_re !== rows[i].want_re || y.win_im !== rows[i].want_im ||
                y.frame_end !== rows[i].want_end || y.status !== rows[i].want_status)
               report_mismatch("directed row", i, -1);
         end
      end
      req_push <= 1'b0;
      drain();

      // every window kind and mode, with bad kind and bad mode
      for (int k = 0; k < 8; k++) begin
         write_reg(CSR_WINDOW_KIND, 27'(k));
         write_reg(CSR_SCALING_MODE, 27'(k % 4));
         write_reg(CSR_SAMPLE_RATE, (k % 2) ? 27'd100000000 : 27'd1);
         write_reg(CSR_WINDOW_LENGTH, (k == 7) ? 27'd0 : 27'd3);
         for (int j = 0; j < 3; j++) begin
            x.sample_re = rand_part();
            x.sample_im = rand_part();
            send_sample(x);
         end
         req_push <= 1'b0;
         drain();   // sender holds off until all results are back
      end

      // random phases: mostly valid configs, short frames; long lengths cut mid-frame
      for (int ph = 0; ph < 24; ph++) begin
         kind_sel = $urandom_range(0, 9);
         write_reg(CSR_WINDOW_KIND, (kind_sel < 9) ? 27'(kind_sel % 4) :
                   27'($urandom_range(4, 7)));
         write_reg(CSR_SCALING_MODE, ($urandom_range(0, 7) == 0) ?
                   27'($urandom_range(2, 3)) : 27'($urandom_range(0, 1)));
         case ($urandom_range(0, 3))
            0: rate = 27'd1;
            1: rate = 27'd100000000;
            2: rate = 27'h7FFFFFF;
            default: rate = 27'($urandom_range(1, 100000000));
         endcase
         write_reg(CSR_SAMPLE_RATE, rate);
         if (ph == 5)
            write_reg(CSR_WINDOW_LENGTH, 27'd4096);
         else if (ph == 9)
            write_reg(CSR_WINDOW_LENGTH, 27'h1FFF);
         else
            write_reg(CSR_WINDOW_LENGTH, 27'($urandom_range(0, 24)));
         if (ph >= 20) quiet = 1;
         for (int j = 0; j < 18; j++) begin
            x.sample_re = rand_part();
            x.sample_im = rand_part();
            send_sample(x);
         end
         req_push <= 1'b0;
         drain();
      end

      if (error_count == 0) begin
         $display("tb_spectral_window_with_scale: done, clean");
      end else begin
         $display("tb_spectral_window_with_scale: done, errors");
      end
      $finish;
   end

endmodule
